// ----- sv/scfq_pkg.sv -----
// Shared types and constants for the SPI command frame queue.
package scfq_pkg;

    // Event codes on the command input.
    localparam logic [1:0] EV_BYTE = 2'd0;
    localparam logic [1:0] EV_SEL  = 2'd1;
    localparam logic [1:0] EV_TAKE = 2'd2;
    localparam logic [1:0] EV_DONE = 2'd3;

    // Opcode of a status read frame, which is never queued.
    localparam logic [7:0] OPC_READ_STATUS = 8'h01;

    localparam int QUEUE_DEPTH_DEF = 4;

    // One classified event as it travels from the front to the back.
    typedef struct packed {
        logic       is_byte;
        logic       is_sel;
        logic       is_take;
        logic       is_done;
        logic [7:0] rx_byte;
        logic       rd_upd;
        logic [7:0] read_data;
        logic       er_upd;
        logic [7:0] error_value;
    } t_evt;

endpackage

// ----- sv/scfq_front.sv -----
// Front part: accepts input beats, classifies them and buffers them in a two-entry queue.
module scfq_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [1:0]       i_command,
    input  logic [7:0]       i_rx_byte,
    input  logic             i_read_data_update,
    input  logic [7:0]       i_read_data,
    input  logic             i_error_update,
    input  logic [7:0]       i_error_value,
    output logic             o_ev_valid,
    input  logic             i_ev_ready,
    output scfq_pkg::t_evt   o_ev
);
    import scfq_pkg::*;

    t_evt       r_slot [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;
    t_evt       w_evt;
    logic       w_push;
    logic       w_pop;

    always_comb begin
        w_evt = '0;
        case (i_command)
            EV_BYTE: w_evt.is_byte = 1'b1;
            EV_SEL:  w_evt.is_sel  = 1'b1;
            EV_TAKE: w_evt.is_take = 1'b1;
            EV_DONE: w_evt.is_done = 1'b1;
            default: w_evt.is_sel  = 1'b0;
        endcase
        w_evt.rx_byte     = i_rx_byte;
        // The update flags only matter on a done event.
        w_evt.rd_upd      = (i_command == EV_DONE) & i_read_data_update;
        w_evt.read_data   = i_read_data;
        w_evt.er_upd      = (i_command == EV_DONE) & i_error_update;
        w_evt.error_value = i_error_value;
    end

    assign o_ready    = (r_cnt != 2'd2);
    assign o_ev_valid = (r_cnt != 2'd0);
    assign o_ev       = r_slot[r_rd];
    assign w_push     = i_valid & o_ready;
    assign w_pop      = o_ev_valid & i_ev_ready;

    always_comb begin
        n_cnt = r_cnt;
        case ({w_push, w_pop})
            2'b10:   n_cnt = r_cnt + 2'd1;
            2'b01:   n_cnt = r_cnt - 2'd1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (w_push) begin
                r_wr <= ~r_wr;
            end
            if (w_pop) begin
                r_rd <= ~r_rd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wr] <= w_evt;
        end
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("front queue count out of range");

endmodule

// ----- sv/scfq_back.sv -----
// Back part: runs the frame engine and command queue and holds the result register.
module scfq_back #(
    parameter int QUEUE_DEPTH = scfq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_ev_valid,
    output logic             o_ev_ready,
    input  scfq_pkg::t_evt   i_ev,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [7:0]       o_tx_byte,
    output logic             o_cmd_valid,
    output logic [7:0]       o_cmd_opcode,
    output logic [15:0]      o_cmd_address,
    output logic [7:0]       o_cmd_data,
    output logic [2:0]       o_pending
);
    import scfq_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [31:0]      r_mem [QUEUE_DEPTH];
    logic [1:0]       r_phase;
    logic [23:0]      r_frame;
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [7:0]       r_last_read;
    logic [7:0]       r_err;
    logic [7:0]       r_next_tx;
    logic             r_busy;

    logic             r_out_valid;
    logic [7:0]       r_tx;
    logic             r_take;
    logic [31:0]      r_rd_word;
    logic [2:0]       r_pend;

    logic [1:0]       n_phase;
    logic [23:0]      n_frame;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] n_rd_ptr;
    logic [CNT_W-1:0] n_count;
    logic [7:0]       n_last_read;
    logic [7:0]       n_err;
    logic [7:0]       n_next_tx;
    logic             n_busy;
    logic [7:0]       n_tx;
    logic             n_take;

    logic             w_exec;
    logic             w_push_cmd;
    logic [31:0]      w_word;
    logic [CNT_W+2:0] w_cnt_ext;

    assign o_ev_ready = ~r_out_valid | i_ready;
    assign w_exec     = i_ev_valid & o_ev_ready;
    assign w_word     = {r_frame, i_ev.rx_byte};

    always_comb begin
        n_phase     = r_phase;
        n_frame     = r_frame;
        n_wr_ptr    = r_wr_ptr;
        n_rd_ptr    = r_rd_ptr;
        n_count     = r_count;
        n_last_read = r_last_read;
        n_err       = r_err;
        n_next_tx   = r_next_tx;
        n_busy      = r_busy;
        n_tx        = 8'h00;
        n_take      = 1'b0;
        w_push_cmd  = 1'b0;
        if (i_ev.is_byte) begin
            n_tx = r_next_tx;
            case (r_phase)
                2'd0: begin
                    n_frame[23:16] = i_ev.rx_byte;
                    n_next_tx      = r_err | {7'd0, (r_count != '0)};
                    n_phase        = 2'd1;
                end
                2'd1: begin
                    n_frame[15:8] = i_ev.rx_byte;
                    n_next_tx     = r_last_read;
                    n_phase       = 2'd2;
                end
                2'd2: begin
                    n_frame[7:0] = i_ev.rx_byte;
                    n_next_tx    = r_frame[23:16];
                    n_phase      = 2'd3;
                end
                default: begin
                    n_next_tx = i_ev.rx_byte;
                    n_phase   = 2'd0;
                    // A full queue drops the frame without a trace.
                    if (r_frame[23:16] != OPC_READ_STATUS &&
                        r_count < CNT_W'(QUEUE_DEPTH)) begin
                        w_push_cmd = 1'b1;
                        n_wr_ptr   = (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ?
                                     '0 : r_wr_ptr + PTR_W'(1);
                        n_count    = r_count + CNT_W'(1);
                    end
                end
            endcase
        end else if (i_ev.is_sel) begin
            n_phase   = 2'd0;
            n_next_tx = 8'h00;
        end else if (i_ev.is_take) begin
            // Without an outstanding command, a nonzero count means an untaken entry.
            if (!r_busy && r_count != '0) begin
                n_take   = 1'b1;
                n_busy   = 1'b1;
                n_rd_ptr = (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ?
                           '0 : r_rd_ptr + PTR_W'(1);
            end
        end else if (i_ev.is_done) begin
            if (r_busy) begin
                n_busy = 1'b0;
                if (r_count != '0) begin
                    n_count = r_count - CNT_W'(1);
                end
                if (i_ev.rd_upd) begin
                    n_last_read = i_ev.read_data;
                end
                if (i_ev.er_upd) begin
                    n_err = i_ev.error_value;
                end
            end
        end
    end

    assign w_cnt_ext = {3'b000, n_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= 2'd0;
            r_frame     <= '0;
            r_wr_ptr    <= '0;
            r_rd_ptr    <= '0;
            r_count     <= '0;
            r_last_read <= 8'h00;
            r_err       <= 8'h00;
            r_next_tx   <= 8'h00;
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_exec) begin
                r_phase     <= n_phase;
                r_frame     <= n_frame;
                r_wr_ptr    <= n_wr_ptr;
                r_rd_ptr    <= n_rd_ptr;
                r_count     <= n_count;
                r_last_read <= n_last_read;
                r_err       <= n_err;
                r_next_tx   <= n_next_tx;
                r_busy      <= n_busy;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result register and command memory read; they only move when an event executes.
    always_ff @(posedge i_clk) begin
        if (w_exec) begin
            r_tx      <= n_tx;
            r_take    <= n_take;
            r_pend    <= w_cnt_ext[2:0];
            r_rd_word <= r_mem[r_rd_ptr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_exec && w_push_cmd) begin
            r_mem[r_wr_ptr] <= w_word;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_tx_byte     = r_tx;
    assign o_cmd_valid   = r_take;
    assign o_cmd_opcode  = r_take ? r_rd_word[31:24] : 8'h00;
    assign o_cmd_address = r_take ? r_rd_word[23:8]  : 16'h0000;
    assign o_cmd_data    = r_take ? r_rd_word[7:0]   : 8'h00;
    assign o_pending     = r_pend;

    a_busy_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_count != '0))
        else $error("outstanding command without a queued entry");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(QUEUE_DEPTH))
        else $error("command count above queue depth");

    a_take_sets_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_exec && i_ev.is_take && !r_busy && r_count != '0) |=> (r_busy && r_take))
        else $error("take did not deliver a command");

endmodule

// ----- sv/spi_command_frame_queue_top.sv -----
// An accepted beat is held in a front queue slot, then executed into the result register.
// Throughput: one event per cycle while i_ready does not stall the result register.
// A two-entry queue between front and back and a result register decouple the channels.
// Reset (synchronous, active low) empties both queues, zeroes the frame, counters and
// status bytes; command memory contents are undefined until written.
module spi_command_frame_queue_top #(
    parameter int QUEUE_DEPTH = scfq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_command,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_read_data_update,
    input  logic [7:0]  i_read_data,
    input  logic        i_error_update,
    input  logic [7:0]  i_error_value,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_tx_byte,
    output logic        o_cmd_valid,
    output logic [7:0]  o_cmd_opcode,
    output logic [15:0] o_cmd_address,
    output logic [7:0]  o_cmd_data,
    output logic [2:0]  o_pending
);
    import scfq_pkg::*;

    logic w_ev_valid;
    logic w_ev_ready;
    t_evt w_ev;

    scfq_front u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_command          (i_command),
        .i_rx_byte          (i_rx_byte),
        .i_read_data_update (i_read_data_update),
        .i_read_data        (i_read_data),
        .i_error_update     (i_error_update),
        .i_error_value      (i_error_value),
        .o_ev_valid         (w_ev_valid),
        .i_ev_ready         (w_ev_ready),
        .o_ev               (w_ev)
    );

    scfq_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ev_valid    (w_ev_valid),
        .o_ev_ready    (w_ev_ready),
        .i_ev          (w_ev),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_tx_byte     (o_tx_byte),
        .o_cmd_valid   (o_cmd_valid),
        .o_cmd_opcode  (o_cmd_opcode),
        .o_cmd_address (o_cmd_address),
        .o_cmd_data    (o_cmd_data),
        .o_pending     (o_pending)
    );

endmodule
